>>> src/hrbb_pkg.sv
// package: payload types and fixed widths of the hot region bounding box unit
`timescale 1ns / 1ps
`default_nettype none
package hrbb_pkg;

  localparam int COORD_BITS   = 12;
  localparam int TEMP_BITS    = 16;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_BITS     = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_HOT_THRESHOLD   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMNS_PER_ROW = 1'b1;

  localparam logic signed [TEMP_BITS-1:0] HOT_THRESHOLD_RESET = 16'sd960;
  localparam logic [COORD_BITS-1:0]       COLUMNS_RESET       = 12'd320;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] pixel_temp;
    logic                        frame_end;
  } in_beat_t;

  typedef struct packed {
    logic                        hot_found;
    logic [COORD_BITS-1:0]       box_top_row;
    logic [COORD_BITS-1:0]       box_left_col;
    logic [COORD_BITS-1:0]       box_bottom_row;
    logic [COORD_BITS-1:0]       box_right_col;
    logic signed [TEMP_BITS-1:0] frame_min_temp;
    logic [TEMP_BITS-2:0]        frame_max_temp;
  } out_beat_t;

endpackage
`default_nettype wire

>>> src/hrbb_frame_stats.sv
// frame statistics: position counters, running min and max, hot pixel box
`timescale 1ns / 1ps
`default_nettype none
module hrbb_frame_stats
  import hrbb_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire in_beat_t                    pixel,
  input  wire logic signed [TEMP_BITS-1:0] hot_threshold,
  input  wire logic [COORD_BITS-1:0]       columns_per_row,
  output out_beat_t                        summary
);

  logic [COORD_BITS-1:0]       col_count_r, col_count_nxt;
  logic [COORD_BITS-1:0]       row_count_r, row_count_nxt;
  logic signed [TEMP_BITS-1:0] run_min_r, run_min_nxt;
  logic signed [TEMP_BITS-1:0] run_max_r, run_max_nxt;
  logic [COORD_BITS-1:0]       top_r, top_nxt;
  logic [COORD_BITS-1:0]       left_r, left_nxt;
  logic [COORD_BITS-1:0]       bottom_r, bottom_nxt;
  logic [COORD_BITS-1:0]       right_r, right_nxt;
  logic                        hot_seen_r, hot_seen_nxt;
  logic                        is_hot;
  logic [COORD_BITS:0]         col_inc;

  assign is_hot  = pixel.pixel_temp > hot_threshold;
  assign col_inc = {1'b0, col_count_r} + {{COORD_BITS{1'b0}}, 1'b1};

  // updated frame state including the current pixel
  always_comb begin
    run_min_nxt  = (pixel.pixel_temp < run_min_r) ? pixel.pixel_temp : run_min_r;
    run_max_nxt  = (pixel.pixel_temp > run_max_r) ? pixel.pixel_temp : run_max_r;
    top_nxt      = top_r;
    left_nxt     = left_r;
    bottom_nxt   = bottom_r;
    right_nxt    = right_r;
    hot_seen_nxt = hot_seen_r;
    if (is_hot) begin
      if (row_count_r < top_r)    top_nxt    = row_count_r;
      if (col_count_r < left_r)   left_nxt   = col_count_r;
      if (row_count_r > bottom_r) bottom_nxt = row_count_r;
      if (col_count_r > right_r)  right_nxt  = col_count_r;
      hot_seen_nxt = 1'b1;
    end
    // zero columns behaves as one since the compare is always true
    if (col_inc >= {1'b0, columns_per_row}) begin
      col_count_nxt = '0;
      row_count_nxt = row_count_r + {{(COORD_BITS-1){1'b0}}, 1'b1};
    end else begin
      col_count_nxt = col_inc[COORD_BITS-1:0];
      row_count_nxt = row_count_r;
    end
  end

  // summary of the frame as it stands after this pixel
  always_comb begin
    summary.hot_found      = hot_seen_nxt;
    summary.box_top_row    = hot_seen_nxt ? top_nxt    : '0;
    summary.box_left_col   = hot_seen_nxt ? left_nxt   : '0;
    summary.box_bottom_row = hot_seen_nxt ? bottom_nxt : '0;
    summary.box_right_col  = hot_seen_nxt ? right_nxt  : '0;
    summary.frame_min_temp = run_min_nxt;
    summary.frame_max_temp = run_max_nxt[TEMP_BITS-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && pixel.frame_end)) begin
      col_count_r <= '0;
      row_count_r <= '0;
      run_min_r   <= '0;
      run_max_r   <= '0;
      top_r       <= '1;
      left_r      <= '1;
      bottom_r    <= '0;
      right_r     <= '0;
      hot_seen_r  <= 1'b0;
    end else if (step) begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
      run_min_r   <= run_min_nxt;
      run_max_r   <= run_max_nxt;
      top_r       <= top_nxt;
      left_r      <= left_nxt;
      bottom_r    <= bottom_nxt;
      right_r     <= right_nxt;
      hot_seen_r  <= hot_seen_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/hot_region_bounding_box_unit.sv
// top level: hot region bounding box unit with frame min and max
`timescale 1ns / 1ps
`default_nettype none
// Takes a thermal frame one pixel beat at a time in raster order (signed
// temperatures in 1/16 degree steps) and emits one summary beat on the beat
// marked frame_end: whether any pixel was strictly hotter than hot_threshold,
// the bounding box of those pixels (all zero when none), and the frame min
// and max, both starting from zero. A pixel beat enters an input register and
// is folded into the frame state as it leaves that register; the summary waits
// in an output register. One pixel is taken per cycle; the only stall is a
// frame_end beat held in the input register while an earlier summary is not
// yet taken. Register writes act at once and do not clear frame state; write
// them only while the block is idle.
module hot_region_bounding_box_unit
  import hrbb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire in_beat_t                in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output out_beat_t                    out_data,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  // configuration registers
  logic signed [TEMP_BITS-1:0] hot_threshold_r;
  logic [COORD_BITS-1:0]       columns_per_row_r;

  // input register
  logic     in_valid_r, in_valid_nxt;
  in_beat_t in_data_r;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_data_r;
  out_beat_t summary;

  logic step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hot_threshold_r   <= HOT_THRESHOLD_RESET;
      columns_per_row_r <= COLUMNS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOT_THRESHOLD:   hot_threshold_r   <= cfg_wdata[TEMP_BITS-1:0];
        REG_COLUMNS_PER_ROW: columns_per_row_r <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // a pixel moves on unless it closes a frame and the summary slot is busy
  assign step     = in_valid_r && (!in_data_r.frame_end || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) in_valid_nxt = 1'b1;
    else if (step)            in_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (step && in_data_r.frame_end) out_valid_nxt = 1'b1;
    else if (out_ready)              out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (step && in_data_r.frame_end) out_data_r <= summary;
  end

  hrbb_frame_stats u_stats (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .pixel           (in_data_r),
    .hot_threshold   (hot_threshold_r),
    .columns_per_row (columns_per_row_r),
    .summary         (summary)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> tb/tb_hot_region_bounding_box_unit.sv
// testbench: hot region bounding box unit checked beat by beat against a frame tracker
`timescale 1ns / 1ps
module tb_hot_region_bounding_box_unit;
  import hrbb_pkg::*;

  // clock, reset and block inputs, all known from time zero
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  in_beat_t                in_data   = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_beat_t               out_data;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_HOT_THRESHOLD;
  logic [CFG_BITS-1:0]     cfg_wdata = '0;

  // idle rates in percent, and a long receiver hold-off counted down by the receiver
  int send_idle_pct     = 0;
  int recv_idle_pct     = 0;
  int ready_hold_cycles = 0;
  int mismatch_count    = 0;

  // frame tracker: shadow registers and running frame state
  logic signed [TEMP_BITS-1:0] hot_thr;
  logic [COORD_BITS-1:0]       row_len;
  logic [COORD_BITS-1:0]       cur_col;
  logic [COORD_BITS-1:0]       cur_row;
  logic signed [TEMP_BITS-1:0] low_temp;
  logic signed [TEMP_BITS-1:0] high_temp;
  logic [COORD_BITS-1:0]       top_edge;
  logic [COORD_BITS-1:0]       left_edge;
  logic [COORD_BITS-1:0]       bottom_edge;
  logic [COORD_BITS-1:0]       right_edge;
  logic                        hot_seen;

  // summaries predicted but not yet seen on the result channel
  out_beat_t pending_summaries[$];

  hot_region_bounding_box_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // frame state back to its start: min edges all ones, everything else zero
  function automatic void clear_frame();
    cur_col     = '0;
    cur_row     = '0;
    low_temp    = '0;
    high_temp   = '0;
    top_edge    = '1;
    left_edge   = '1;
    bottom_edge = '0;
    right_edge  = '0;
    hot_seen    = 1'b0;
  endfunction

  // fold one accepted pixel beat into the tracker, queue a summary on frame_end
  task automatic track_pixel(in_beat_t px);
    out_beat_t s;
    if (px.pixel_temp > high_temp) high_temp = px.pixel_temp;
    if (px.pixel_temp < low_temp) low_temp = px.pixel_temp;
    // hot means strictly above the threshold
    if (px.pixel_temp > hot_thr) begin
      if (cur_row < top_edge) top_edge = cur_row;
      if (cur_col < left_edge) left_edge = cur_col;
      if (cur_row > bottom_edge) bottom_edge = cur_row;
      if (cur_col > right_edge) right_edge = cur_col;
      hot_seen = 1'b1;
    end
    if (px.frame_end) begin
      // box reads zero when nothing in the frame was hot
      s.hot_found      = hot_seen;
      s.box_top_row    = hot_seen ? top_edge : '0;
      s.box_left_col   = hot_seen ? left_edge : '0;
      s.box_bottom_row = hot_seen ? bottom_edge : '0;
      s.box_right_col  = hot_seen ? right_edge : '0;
      s.frame_min_temp = low_temp;
      s.frame_max_temp = high_temp[TEMP_BITS-2:0];
      pending_summaries.push_back(s);
      clear_frame();
    end else if (int'(cur_col) + 1 >= int'(row_len)) begin
      // wrap at or past the row length; a row length of zero acts like one
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
  endtask

  task automatic cmp_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_summary(out_beat_t got);
    out_beat_t want;
    if (pending_summaries.size() == 0) begin
      $error("summary beat arrived with no frame pending");
      mismatch_count++;
    end else begin
      want = pending_summaries.pop_front();
      cmp_field("hot_found", want.hot_found, got.hot_found);
      cmp_field("box_top_row", want.box_top_row, got.box_top_row);
      cmp_field("box_left_col", want.box_left_col, got.box_left_col);
      cmp_field("box_bottom_row", want.box_bottom_row, got.box_bottom_row);
      cmp_field("box_right_col", want.box_right_col, got.box_right_col);
      cmp_field("frame_min_temp", want.frame_min_temp, got.frame_min_temp);
      cmp_field("frame_max_temp", want.frame_max_temp, got.frame_max_temp);
    end
  endtask

  // result side: sample at the edge, then pick the ready for the next cycle
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ready === 1'b1 && out_valid !== 1'b0) check_summary(out_data);
      if (ready_hold_cycles > 0) begin
        out_ready <= 1'b0;
        ready_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // one pixel beat: optional idle gap, then hold valid until accepted
  task automatic send_pixel(int temp, bit last);
    in_beat_t b;
    b.pixel_temp = temp[TEMP_BITS-1:0];
    b.frame_end  = last;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    track_pixel(b);
  endtask

  // sender pauses until every summary is back and the pipeline has emptied
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register writes only go in while the block is idle
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    drain_block();
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_HOT_THRESHOLD) hot_thr = data;
    else if (idx == REG_COLUMNS_PER_ROW) row_len = data[COORD_BITS-1:0];
  endtask

  task automatic set_threshold(int thr);
    write_reg(REG_HOT_THRESHOLD, thr[CFG_BITS-1:0]);
  endtask

  // upper data bits are junk on purpose, the register keeps only its low bits
  task automatic set_columns(int cols);
    logic [CFG_BITS-1:0] data;
    data = CFG_BITS'($urandom);
    data[COORD_BITS-1:0] = cols[COORD_BITS-1:0];
    write_reg(REG_COLUMNS_PER_ROW, data);
  endtask

  // temperatures: mostly near the threshold, some full range, some near zero
  function automatic int pick_temp();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 65535)) - 32768;
      1, 2:    v = int'(hot_thr) + int'($urandom_range(0, 128)) - 64;
      default: v = int'($urandom_range(0, 400)) - 200;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int pick_columns();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 4095;
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  task automatic randomize_regs();
    case ($urandom_range(0, 5))
      0:       set_threshold(-32768);
      1:       set_threshold(32767);
      2:       set_threshold(int'($urandom_range(0, 65535)) - 32768);
      default: set_threshold(int'($urandom_range(0, 1200)) - 200);
    endcase
    set_columns(pick_columns());
  endtask

  task automatic send_temps(int temps[$], bit close);
    foreach (temps[i]) send_pixel(temps[i], close && i == temps.size() - 1);
  endtask

  task automatic send_pixels(int count, bit close);
    for (int i = 0; i < count; i++) send_pixel(pick_temp(), close && i == count - 1);
  endtask

  // reset values: threshold 960, 320 columns
  task automatic test_reset_values();
    // hot on first pixel, threshold itself is not hot, both temperature extremes
    send_temps('{961, 960, -32768, 32767}, 1);
    // all positive so the min stays at zero, hot on the closing pixel
    send_temps('{5, 961}, 1);
    // single cold negative pixel: max stays zero, box reads zero
    send_temps('{-100}, 1);
    drain_block();
  endtask

  task automatic test_column_wrap();
    set_threshold(0);
    set_columns(3);
    send_temps('{0, 9, -1, 0, 0, 9, 9}, 1);
    // zero columns: every pixel its own row
    set_columns(0);
    send_temps('{9, 0, 9}, 1);
    // shrink the row mid frame with the column count already past the new length
    set_columns(8);
    send_temps('{0, 0, 0, 0, 9, 0}, 0);
    set_columns(2);
    send_temps('{9, 9}, 1);
    drain_block();
  endtask

  task automatic test_threshold_extremes();
    set_threshold(-32768);
    send_temps('{-32768, -32767}, 1);
    set_threshold(32767);
    send_temps('{32767, 0}, 1);
    drain_block();
  endtask

  // one pixel per row for more than 4096 rows so the row count wraps
  task automatic test_row_wrap();
    set_threshold(100);
    set_columns(1);
    for (int i = 0; i < 4100; i++)
      send_pixel((i == 3 || i == 4095 || i == 4098) ? 200 : int'($urandom_range(0, 400)) - 300,
                 i == 4099);
    drain_block();
  endtask

  // widest row: hot pixel on the last column, then one on the next row
  task automatic test_wide_rows();
    set_threshold(100);
    set_columns(4095);
    for (int i = 0; i < 4097; i++)
      send_pixel((i == 4094 || i == 4096) ? 32767 : int'($urandom_range(0, 400)) - 300,
                 i == 4096);
    drain_block();
  endtask

  // mostly short frames so summaries come often, now and then a long one,
  // register changes between frames and sometimes in the middle of one
  task automatic test_random(int sp, int rp, int n);
    int sent;
    int len;
    int cut;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 7) == 0) randomize_regs();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      if ($urandom_range(0, 11) == 0) begin
        cut = $urandom_range(1, 20);
        send_pixels(cut, 0);
        set_columns(pick_columns());
        sent += cut;
      end
      send_pixels(len, 1);
      sent += len;
    end
    drain_block();
  endtask

  // receiver holds off long while tiny frames keep coming, so the block stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_block();
    ready_hold_cycles = 300;
    repeat (40) send_pixels($urandom_range(1, 2), 1);
    drain_block();
    repeat (20) send_pixels($urandom_range(1, 3), 1);
    drain_block();
  endtask

  initial begin
    hot_thr = HOT_THRESHOLD_RESET;
    row_len = COLUMNS_RESET;
    clear_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 70;
    test_reset_values();
    test_column_wrap();
    test_threshold_extremes();
    test_row_wrap();
    test_wide_rows();
    test_random(14, 70, 700);
    test_random(70, 14, 700);
    test_random(0, 0, 700);
    test_backpressure();
    drain_block();
    if (mismatch_count == 0) $display("tb_hot_region_bounding_box_unit: done, clean");
    else $display("tb_hot_region_bounding_box_unit: done, errors");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("tb_hot_region_bounding_box_unit: done, errors");
    $finish;
  end

endmodule
